// ===== rtl/core/plid_pkg.sv =====
package plid_pkg;

  localparam int unsigned OP_W        = 2;
  localparam int unsigned POS_W       = 7;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned CNT_OUT_W   = 7;
  localparam int unsigned RESET_COUNT = 5;

  typedef enum logic [OP_W-1:0] {
    OP_DISPLAY = 2'd0,
    OP_INSERT  = 2'd1,
    OP_DELETE  = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_t;

  typedef struct packed {
    status_t                 status;
    logic [CNT_OUT_W-1:0]    count_after;
    logic signed [VAL_W-1:0] elem_value;
    logic                    last;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic edit;
    logic disp_load;
    logic disp_step;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic q_full;
    logic q_space;
    logic cnt_zero;
    logic disp_end;
  } sts_t;

endpackage

// ===== rtl/core/positional_list_insert_delete.sv =====
// Insert and delete: the result word enters the output queue in the cycle the item is
// accepted; back-to-back edits sustain one item per cycle while the queue is not full.
// Display: the controller enters S_DISP, then pushes one word per cycle from the
// rotating entry chain while the queue has space, and stalls the input until the last word.
// Reset (synchronous, rst_n low) loads entries 1 to 5, count 5, and empties the output queue.
module positional_list_insert_delete #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [plid_pkg::OP_W-1:0]         in_op,
  input  logic [plid_pkg::POS_W-1:0]        in_position,
  input  logic signed [plid_pkg::VAL_W-1:0] in_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [plid_pkg::CNT_OUT_W-1:0]    out_count_after,
  output logic signed [plid_pkg::VAL_W-1:0] out_elem_value,
  output logic                              out_last
);

  plid_pkg::cmd_t cmd;
  plid_pkg::sts_t sts;

  plid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .sts      (sts),
    .cmd      (cmd)
  );

  plid_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_value        (in_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_count_after (out_count_after),
    .out_elem_value  (out_elem_value),
    .out_last        (out_last)
  );

endmodule

// ===== rtl/core/plid_ctrl.sv =====
module plid_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [plid_pkg::OP_W-1:0] in_op,
  input  plid_pkg::sts_t            sts,
  output plid_pkg::cmd_t            cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_DISP = 2'b10
  } state_t;

  state_t        state_r;
  state_t        state_nxt;
  plid_pkg::op_t op_c;

  assign op_c = plid_pkg::op_t'(in_op);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        in_stall = sts.q_full;
        if (in_valid && !sts.q_full) begin
          case (op_c) inside
            plid_pkg::OP_DISPLAY: begin
              // empty list: drop the request, nothing to stream
              if (!sts.cnt_zero) begin
                cmd.disp_load = 1'b1;
                state_nxt     = S_DISP;
              end
            end
            plid_pkg::OP_INSERT, plid_pkg::OP_DELETE: begin
              cmd.edit = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_DISP: begin
        if (sts.q_space) begin
          cmd.disp_step = 1'b1;
          if (sts.disp_end) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/core/plid_dpath.sv =====
module plid_dpath #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [plid_pkg::OP_W-1:0]              in_op,
  input  logic [plid_pkg::POS_W-1:0]             in_position,
  input  logic signed [plid_pkg::VAL_W-1:0]      in_value,
  input  plid_pkg::cmd_t                         cmd,
  output plid_pkg::sts_t                         sts,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [1:0]                             out_status,
  output logic [plid_pkg::CNT_OUT_W-1:0]         out_count_after,
  output logic signed [plid_pkg::VAL_W-1:0]      out_elem_value,
  output logic                                   out_last
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic signed [plid_pkg::VAL_W-1:0] cell_r   [DEPTH];
  logic signed [plid_pkg::VAL_W-1:0] cell_nxt [DEPTH];
  logic [CNT_W-1:0]                  count_r;
  logic [CNT_W-1:0]                  count_nxt;
  logic [IDX_W-1:0]                  idx_r;

  plid_pkg::op_t                      op_c;
  plid_pkg::status_t                  edit_st;
  logic [plid_pkg::CNT_OUT_W-1:0]     cnt_ext;
  logic                               ins_ok;
  logic                               del_ok;
  logic                               disp_end;

  plid_pkg::res_t q_r [2];
  logic [1:0]     q_cnt_r;
  logic [1:0]     q_cnt_nxt;
  logic           push;
  logic           pop;
  logic           wr_sel;
  plid_pkg::res_t push_word;

  assign op_c    = plid_pkg::op_t'(in_op);
  assign cnt_ext = plid_pkg::CNT_OUT_W'(count_r);

  // full / empty checks take priority over the position check
  always_comb begin
    edit_st = plid_pkg::ST_OK;
    ins_ok  = 1'b0;
    del_ok  = 1'b0;
    case (op_c)
      plid_pkg::OP_INSERT: begin
        if (count_r == CNT_W'(DEPTH)) begin
          edit_st = plid_pkg::ST_FULL;
        end else if (in_position > cnt_ext) begin
          edit_st = plid_pkg::ST_BADPOS;
        end else begin
          ins_ok = cmd.edit;
        end
      end
      plid_pkg::OP_DELETE: begin
        if (count_r == '0) begin
          edit_st = plid_pkg::ST_EMPTY;
        end else if (in_position >= cnt_ext) begin
          edit_st = plid_pkg::ST_BADPOS;
        end else begin
          del_ok = cmd.edit;
        end
      end
      default: begin
        edit_st = plid_pkg::ST_OK;
      end
    endcase
  end

  assign disp_end = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);

  // entry cells: shift up on insert, down on delete, rotate the live part on display
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [plid_pkg::VAL_W-1:0] prev_w;
    logic signed [plid_pkg::VAL_W-1:0] next_w;

    if (g > 0) begin : g_prev
      assign prev_w = cell_r[g-1];
    end else begin : g_prev0
      assign prev_w = cell_r[g];
    end

    if (g < DEPTH - 1) begin : g_next
      assign next_w = cell_r[g+1];
    end else begin : g_next_last
      assign next_w = cell_r[g];
    end

    always_comb begin
      cell_nxt[g] = cell_r[g];
      if (ins_ok) begin
        if (plid_pkg::POS_W'(g) == in_position) begin
          cell_nxt[g] = in_value;
        end else if (plid_pkg::POS_W'(g) > in_position) begin
          cell_nxt[g] = prev_w;
        end
      end else if (del_ok) begin
        if (plid_pkg::POS_W'(g) >= in_position) begin
          cell_nxt[g] = next_w;
        end
      end else if (cmd.disp_step) begin
        if (CNT_W'(g + 1) == count_r) begin
          cell_nxt[g] = cell_r[0];
        end else if (CNT_W'(g + 1) < count_r) begin
          cell_nxt[g] = next_w;
        end
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ins_ok) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (del_ok) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_r[i] <= (i < plid_pkg::RESET_COUNT) ? plid_pkg::VAL_W'(i + 1) : '0;
      end
      count_r <= CNT_W'(plid_pkg::RESET_COUNT);
      idx_r   <= '0;
    end else begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_r[i] <= cell_nxt[i];
      end
      count_r <= count_nxt;
      if (cmd.disp_load) begin
        idx_r <= '0;
      end else if (cmd.disp_step) begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // two-word output queue
  always_comb begin
    push_word = '0;
    if (cmd.disp_step) begin
      push_word.status      = plid_pkg::ST_OK;
      push_word.count_after = cnt_ext;
      push_word.elem_value  = cell_r[0];
      push_word.last        = disp_end;
    end else begin
      push_word.status      = edit_st;
      push_word.count_after = plid_pkg::CNT_OUT_W'(count_nxt);
      push_word.elem_value  = '0;
      push_word.last        = 1'b1;
    end
  end

  assign push      = cmd.edit || cmd.disp_step;
  assign pop       = (q_cnt_r != 2'd0) && !out_stall;
  assign q_cnt_nxt = q_cnt_r + 2'(push) - 2'(pop);
  assign wr_sel    = 1'((q_cnt_r - 2'(pop)) & 2'd1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r <= 2'd0;
    end else begin
      q_cnt_r <= q_cnt_nxt;
    end
  end

  // head takes the new word when the queue drains to it, else advances
  always_ff @(posedge clk) begin
    if (push && !wr_sel) begin
      q_r[0] <= push_word;
    end else if (pop) begin
      q_r[0] <= q_r[1];
    end
    if (push && wr_sel) begin
      q_r[1] <= push_word;
    end
  end

  assign out_valid       = (q_cnt_r != 2'd0);
  assign out_status      = q_r[0].status;
  assign out_count_after = q_r[0].count_after;
  assign out_elem_value  = q_r[0].elem_value;
  assign out_last        = q_r[0].last;

  assign sts.q_full   = (q_cnt_r == 2'd2);
  assign sts.q_space  = (q_cnt_r != 2'd2) || pop;
  assign sts.cnt_zero = (count_r == '0);
  assign sts.disp_end = disp_end;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_queue_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r != 2'd3)
    else $error("output queue overflow");

  a_ins_count: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("insert did not advance count");

  a_del_count: assert property (@(posedge clk) disable iff (!rst_n)
    del_ok |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("delete did not drop count");

  a_disp_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.disp_step && !disp_end |=> $stable(count_r))
    else $error("count changed during display");
`endif

endmodule

// ===== test/positional_list_insert_delete_tb.sv =====
`timescale 1ns / 100ps

module positional_list_insert_delete_tb;

  localparam int DEPTH = 32;
  localparam logic [plid_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CHOKE_CYCLES = 200;
  localparam int TAIL_CYCLES = 60;
  localparam int MAX_REPORTS = 40;

  typedef enum {W_ITEM, W_DRAIN, W_CHOKE} feed_kind_t;

  typedef struct {
    feed_kind_t                        kind;
    logic [plid_pkg::OP_W-1:0]         op;
    logic [plid_pkg::POS_W-1:0]        pos;
    logic signed [plid_pkg::VAL_W-1:0] val;
  } req_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [plid_pkg::OP_W-1:0] in_op = '0;
  logic [plid_pkg::POS_W-1:0] in_position = '0;
  logic signed [plid_pkg::VAL_W-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [plid_pkg::CNT_OUT_W-1:0] out_count_after;
  logic signed [plid_pkg::VAL_W-1:0] out_elem_value;
  logic out_last;

  positional_list_insert_delete #(.DEPTH(DEPTH)) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_count_after (out_count_after),
    .out_elem_value  (out_elem_value),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  req_word_t      pending_words[$];
  plid_pkg::res_t due_results[$];

  // shadow copy of the list
  logic signed [plid_pkg::VAL_W-1:0] list_vals [DEPTH];
  int list_len;
  int plan_len;   // list length as the stimulus planner expects it
  int plan_items;

  int errors = 0;
  int words_in = 0;
  int results_out = 0;
  int n_disp = 0;
  int n_ignored = 0;
  int deepest = 0;
  int status_seen [4];

  task automatic flag_error(input string msg);
    if (errors < MAX_REPORTS)
      $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void list_apply(input req_word_t w);
    plid_pkg::res_t r;
    int i;
    r = '0;
    r.last = 1'b1;
    words_in++;
    case (w.op)
      plid_pkg::OP_DISPLAY: begin
        n_disp++;
        for (i = 0; i < list_len; i++) begin
          r.status = plid_pkg::ST_OK;
          r.count_after = plid_pkg::CNT_OUT_W'(list_len);
          r.elem_value = list_vals[i];
          r.last = (i == list_len - 1);
          due_results.push_back(r);
        end
      end
      plid_pkg::OP_INSERT: begin
        if (list_len >= DEPTH) begin
          r.status = plid_pkg::ST_FULL;
        end else if (w.pos > list_len) begin
          r.status = plid_pkg::ST_BADPOS;
        end else begin
          for (i = list_len; i > w.pos; i--)
            list_vals[i] = list_vals[i-1];
          list_vals[w.pos] = w.val;
          list_len++;
          r.status = plid_pkg::ST_OK;
        end
        r.count_after = plid_pkg::CNT_OUT_W'(list_len);
        status_seen[r.status]++;
        due_results.push_back(r);
      end
      plid_pkg::OP_DELETE: begin
        if (list_len == 0) begin
          r.status = plid_pkg::ST_EMPTY;
        end else if (w.pos >= list_len) begin
          r.status = plid_pkg::ST_BADPOS;
        end else begin
          for (i = w.pos; i + 1 < list_len; i++)
            list_vals[i] = list_vals[i+1];
          list_len--;
          r.status = plid_pkg::ST_OK;
        end
        r.count_after = plid_pkg::CNT_OUT_W'(list_len);
        status_seen[r.status]++;
        due_results.push_back(r);
      end
      default: n_ignored++;
    endcase
    if (list_len > deepest)
      deepest = list_len;
  endfunction

  task automatic queue_mark(input feed_kind_t kind);
    req_word_t w;
    w.kind = kind;
    w.op = OP_UNUSED;
    w.pos = '0;
    w.val = '0;
    pending_words.push_back(w);
  endtask

  task automatic queue_word(input logic [plid_pkg::OP_W-1:0] op, input int pos,
                            input logic signed [plid_pkg::VAL_W-1:0] val);
    req_word_t w;
    w.kind = W_ITEM;
    w.op = op;
    w.pos = plid_pkg::POS_W'(pos);
    w.val = val;
    pending_words.push_back(w);
    if (op != OP_UNUSED)
      plan_items++;
    if (op == plid_pkg::OP_INSERT && plan_len < DEPTH && pos <= plan_len)
      plan_len++;
    else if (op == plid_pkg::OP_DELETE && plan_len > 0 && pos < plan_len)
      plan_len--;
  endtask

  function automatic logic signed [plid_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7FFF_FFFF;
      2: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic int pick_pos(input logic [plid_pkg::OP_W-1:0] op);
    if ($urandom_range(0, 9) == 0 || op == plid_pkg::OP_DISPLAY || op == OP_UNUSED)
      return $urandom_range(0, 64);
    if (op == plid_pkg::OP_INSERT)
      return (plan_len >= DEPTH) ? $urandom_range(0, 64) : $urandom_range(0, plan_len);
    return (plan_len == 0) ? $urandom_range(0, 64) : $urandom_range(0, plan_len - 1);
  endfunction

  // bias: 0 grows the list, 1 shrinks it, 2 keeps it wandering
  task automatic queue_burst(input int n, input int bias);
    int k;
    int roll;
    int ins_cut;
    int del_cut;
    logic [plid_pkg::OP_W-1:0] op;
    ins_cut = (bias == 0) ? 70 : (bias == 1) ? 15 : 42;
    del_cut = (bias == 2) ? 84 : 85;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < ins_cut) op = plid_pkg::OP_INSERT;
      else if (roll < del_cut) op = plid_pkg::OP_DELETE;
      else if (roll < 98) op = plid_pkg::OP_DISPLAY;
      else op = OP_UNUSED;
      queue_word(op, pick_pos(op), pick_value());
    end
  endtask

  // driver
  req_word_t cur_word;
  int burst_left = 0;
  int gap_left = 0;
  logic choke_tog = 1'b0;
  logic choke_seen = 1'b0;
  int hold_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!(in_valid && in_stall)) begin
      if (in_valid)
        list_apply(cur_word);
      if (gap_left > 0 && hold_left == 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_words.size() == 0) begin
        in_valid <= 1'b0;
      end else if (pending_words[0].kind == W_DRAIN) begin
        // hold until every expected result is out
        in_valid <= 1'b0;
        if (due_results.size() == 0)
          void'(pending_words.pop_front());
      end else if (pending_words[0].kind == W_CHOKE) begin
        in_valid <= 1'b0;
        choke_tog <= ~choke_tog;
        void'(pending_words.pop_front());
      end else begin
        cur_word = pending_words.pop_front();
        in_valid <= 1'b1;
        in_op <= cur_word.op;
        in_position <= cur_word.pos;
        in_value <= cur_word.val;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 5) == 0) ? 60 : $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  // receiver stall pattern
  int stall_run = 0;
  int free_run = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      choke_seen <= 1'b0;
    end else if (choke_tog != choke_seen) begin
      choke_seen <= choke_tog;
      hold_left <= CHOKE_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left != 1);
    end else if (stall_run > 0) begin
      stall_run--;
      out_stall <= 1'b1;
    end else if (free_run > 0) begin
      free_run--;
      out_stall <= 1'b0;
    end else begin
      stall_run = $urandom_range(1, 5);
      free_run = $urandom_range(0, 10);
      if ($urandom_range(0, 7) == 0) begin
        stall_run = 0;
        free_run = 60;
      end
      out_stall <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk) begin : watch_results
    plid_pkg::res_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_out++;
      if (due_results.size() == 0) begin
        flag_error($sformatf("unexpected word status %0d count %0d value %0d last %0b",
                             out_status, out_count_after, out_elem_value, out_last));
      end else begin
        want = due_results.pop_front();
        if (out_status !== want.status)
          flag_error($sformatf("result %0d status %0d, want %0d",
                               results_out, out_status, want.status));
        if (out_count_after !== want.count_after)
          flag_error($sformatf("result %0d count_after %0d, want %0d",
                               results_out, out_count_after, want.count_after));
        if (out_elem_value !== want.elem_value)
          flag_error($sformatf("result %0d elem_value %0d, want %0d",
                               results_out, out_elem_value, want.elem_value));
        if (out_last !== want.last)
          flag_error($sformatf("result %0d last %0b, want %0b",
                               results_out, out_last, want.last));
      end
    end
  end

  initial begin
    int i;
    int choked;
    for (i = 0; i < DEPTH; i++)
      list_vals[i] = (i < plid_pkg::RESET_COUNT) ? i + 1 : 0;
    list_len = plid_pkg::RESET_COUNT;
    plan_len = plid_pkg::RESET_COUNT;
    plan_items = 0;
    choked = 0;
    for (i = 0; i < 4; i++)
      status_seen[i] = 0;

    // directed: reset contents, edges of position and value, empty list
    queue_word(plid_pkg::OP_DISPLAY, 0, 0);
    queue_word(plid_pkg::OP_INSERT, 0, 32'sh8000_0000);
    queue_word(plid_pkg::OP_INSERT, 6, 32'sh7FFF_FFFF);
    queue_word(plid_pkg::OP_INSERT, 8, 32'sh1234_5678);
    queue_word(plid_pkg::OP_INSERT, 64, -32'sd1);
    queue_word(plid_pkg::OP_DELETE, 7, 0);
    queue_word(plid_pkg::OP_DELETE, 64, 0);
    queue_word(plid_pkg::OP_DELETE, 3, 0);
    queue_word(OP_UNUSED, 64, -32'sd1);
    queue_word(plid_pkg::OP_DISPLAY, 64, -32'sd1);
    for (i = 0; i < 6; i++)
      queue_word(plid_pkg::OP_DELETE, (i % 2) ? plan_len - 1 : 0, 0);
    queue_word(plid_pkg::OP_DELETE, 0, 0);
    queue_word(plid_pkg::OP_DELETE, 64, 0);
    queue_word(plid_pkg::OP_DISPLAY, 0, 0);
    queue_word(plid_pkg::OP_INSERT, 1, 32'sh5555_5555);
    queue_word(plid_pkg::OP_INSERT, 0, 0);
    queue_word(plid_pkg::OP_DISPLAY, 0, 0);
    queue_mark(W_DRAIN);

    // fill to the top, push against full, then empty it again
    while (plan_len < DEPTH)
      queue_word(plid_pkg::OP_INSERT, $urandom_range(0, plan_len), pick_value());
    queue_word(plid_pkg::OP_INSERT, 64, pick_value());
    queue_word(plid_pkg::OP_INSERT, 0, pick_value());
    queue_word(plid_pkg::OP_DISPLAY, 0, 0);
    while (plan_len > 0)
      queue_word(plid_pkg::OP_DELETE, $urandom_range(0, plan_len - 1), 0);
    queue_word(plid_pkg::OP_DISPLAY, 0, 0);
    queue_mark(W_DRAIN);

    while (plan_items < 360) begin
      if (!choked && plan_items >= 150) begin
        // starve the output while inserts keep coming
        queue_mark(W_CHOKE);
        queue_burst(40, 0);
        queue_mark(W_DRAIN);
        choked = 1;
      end else begin
        queue_burst($urandom_range(20, 50), $urandom_range(0, 2));
        if ($urandom_range(0, 2) == 0)
          queue_mark(W_DRAIN);
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_words.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d words in (%0d displays, %0d ignored), %0d results out",
             words_in, n_disp, n_ignored, results_out);
    $display("status ok %0d, full %0d, empty %0d, bad position %0d; deepest list %0d",
             status_seen[plid_pkg::ST_OK], status_seen[plid_pkg::ST_FULL],
             status_seen[plid_pkg::ST_EMPTY], status_seen[plid_pkg::ST_BADPOS], deepest);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d words pending, %0d results due",
             pending_words.size(), due_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
